// File: design/drc_pkg.sv
// shared types, constants and codes for the dirty region coalescer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package drc_pkg;

   localparam int MaxRanges    = 16;
   localparam int IdxW         = $clog2(MaxRanges);
   localparam int CntW         = $clog2(MaxRanges + 1);
   localparam int NoBlockAlign = 4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BOUNDS   = 2'd1;
   localparam logic [1:0] ST_DENIED   = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic OP_MARK  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [2:0] REG_TEX_WIDTH  = 3'd0;
   localparam logic [2:0] REG_TEX_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TEX_DEPTH  = 3'd2;
   localparam logic [2:0] REG_CPU_BACKED = 3'd3;
   localparam logic [2:0] REG_ALIGN_X    = 3'd4;
   localparam logic [2:0] REG_ALIGN_Y    = 3'd5;
   localparam logic [2:0] REG_STAGED     = 3'd6;

   typedef struct packed {
      logic        operation;
      logic [15:0] box_x;
      logic [15:0] box_y;
      logic [15:0] box_z;
      logic [15:0] box_w;
      logic [15:0] box_h;
      logic [15:0] box_d;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        notify_device;
      logic        entry_valid;
      logic [15:0] out_start_x;
      logic [15:0] out_start_y;
      logic [15:0] out_start_z;
      logic [15:0] out_end_x;
      logic [15:0] out_end_y;
      logic [15:0] out_end_z;
      logic        full_copy;
      logic [4:0]  entry_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } vec3_type;

   typedef struct packed {
      vec3_type s;
      vec3_type e;
   } box_type;

   typedef struct packed {
      logic        start;
      logic [16:0] dividend;
      logic [3:0]  divisor;
   } rem_req_type;

   typedef struct packed {
      logic       done;
      logic [3:0] rem;
   } rem_rsp_type;

endpackage
`default_nettype wire

// File: design/dirty_region_coalescer_core.sv
// A mark that passes the checks runs four block alignments, one after another, in the
// shared remainder unit, then scans the stored ranges, and closes the gap each time
// an older overlapping range is folded in. A drain gives one transfer per entry,
// each held until the receiver takes it. The block takes no new
// item until the last result of the current one has been transferred. Config
// writes are always taken and must only be made while the block is idle.
// depends on drc_pkg and drc_rem_unit
`timescale 1ns / 1ps
`default_nettype none
module dirty_region_coalescer_core
   import drc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_DIV = 4'd2, S_DIVW = 4'd3,
      S_CLASS = 4'd4, S_SCAN = 4'd5, S_SHIFT = 4'd6, S_APPEND = 4'd7,
      S_FINISH = 4'd8, S_DRAIN = 4'd9, S_WAIT = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [15:0] tw_ff, th_ff, td_ff;
   logic        cpu_ff, staged_ff;
   logic [3:0]  bx_ff, by_ff;

   logic        op_ff, op_in;
   vec3_type    p_ff, p_in, s_ff, s_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [16:0] upx_ff, upx_in, upy_ff, upy_in;
   logic [1:0]  dop_ff, dop_in;
   logic        allzero_ff, allzero_in;

   box_type     mem_ff [MaxRanges];
   logic        we;
   logic [IdxW-1:0] wa;
   box_type     wd;
   logic [IdxW-1:0] ra;
   box_type     rd;

   logic [CntW-1:0] cnt_ff, cnt_in;
   logic        pend_ff, pend_in, full_ff, full_in, first_ff, first_in;
   logic [IdxW-1:0] scan_ff, scan_in, k_ff, k_in, match_ff, match_in;
   logic        matched_ff, matched_in;
   box_type     acc_ff, acc_in;
   logic [1:0]  status_ff, status_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   rem_req_type rreq;
   rem_rsp_type rrsp;

   drc_rem_unit u_rem (.clock(clock), .reset(reset), .req(rreq), .rsp(rrsp));

   // alignment per axis
   logic        blk;
   logic [3:0]  ax, ay;
   logic [16:0] vx, vy, upz;
   logic [16:0] ex_p, ey_p, ez_p;
   assign blk = (bx_ff > 4'd1) || (by_ff > 4'd1);
   assign ax  = blk ? ((bx_ff == 4'd0) ? 4'd1 : bx_ff) : 4'(NoBlockAlign);
   assign ay  = blk ? ((by_ff == 4'd0) ? 4'd1 : by_ff) : 4'(NoBlockAlign);
   assign ex_p = {1'b0, p_ff.x} + {1'b0, s_ff.x};
   assign ey_p = {1'b0, p_ff.y} + {1'b0, s_ff.y};
   assign ez_p = {1'b0, p_ff.z} + {1'b0, s_ff.z};
   assign vx  = ex_p + 17'(ax) - 17'd1;
   assign vy  = ey_p + 17'(ay) - 17'd1;
   assign upz = (ez_p + 17'(NoBlockAlign - 1)) & ~17'(NoBlockAlign - 1);

   // bounds and permission on the raw request
   logic bounds_bad, allowed;
   assign bounds_bad = (p_ff.x >= tw_ff) || (ex_p > {1'b0, tw_ff})
                    || (p_ff.y >= th_ff) || (ey_p > {1'b0, th_ff})
                    || (p_ff.z >= td_ff) || (ez_p > {1'b0, td_ff});
   assign allowed = cpu_ff || (first_ff && allzero_ff && staged_ff);

   // merge bounds of the new box, block aligned only when a block format is set
   logic [16:0] rex, rey;
   vec3_type    rs;
   assign rs.x = blk ? lo_ff.x : p_ff.x;
   assign rs.y = blk ? lo_ff.y : p_ff.y;
   assign rs.z = p_ff.z;
   assign rex  = blk ? upx_ff : ex_p;
   assign rey  = blk ? upy_ff : ey_p;

   function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
      min16 = (a < b) ? a : b;
   endfunction
   function automatic logic [15:0] maxsat(input logic [15:0] a, input logic [16:0] b);
      logic [16:0] m;
      m = ({1'b0, a} > b) ? {1'b0, a} : b;
      maxsat = m[16] ? 16'hFFFF : m[15:0];
   endfunction

   logic    ov;
   box_type first_box, fold_box;
   assign rd = mem_ff[ra];
   assign ov = (hi_ff.x >= rd.s.x) && (lo_ff.x <= rd.e.x)
            && (hi_ff.y >= rd.s.y) && (lo_ff.y <= rd.e.y)
            && (hi_ff.z >= rd.s.z) && (lo_ff.z <= rd.e.z);
   always_comb begin
      first_box.s.x = min16(rd.s.x, rs.x);
      first_box.s.y = min16(rd.s.y, rs.y);
      first_box.s.z = min16(rd.s.z, rs.z);
      first_box.e.x = maxsat(rd.e.x, rex);
      first_box.e.y = maxsat(rd.e.y, rey);
      first_box.e.z = maxsat(rd.e.z, ez_p);
      fold_box.s.x  = min16(rd.s.x, acc_ff.s.x);
      fold_box.s.y  = min16(rd.s.y, acc_ff.s.y);
      fold_box.s.z  = min16(rd.s.z, acc_ff.s.z);
      fold_box.e.x  = maxsat(rd.e.x, {1'b0, acc_ff.e.x});
      fold_box.e.y  = maxsat(rd.e.y, {1'b0, acc_ff.e.y});
      fold_box.e.z  = maxsat(rd.e.z, {1'b0, acc_ff.e.z});
   end

   logic [CntW-1:0] k_next;
   assign k_next = CntW'(k_ff) + CntW'(1);
   assign ra = (state_ff == S_SHIFT) ? k_next[IdxW-1:0] : scan_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      upx_in       = upx_ff;
      upy_in       = upy_ff;
      dop_in       = dop_ff;
      allzero_in   = allzero_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      full_in      = full_ff;
      first_in     = first_ff;
      scan_in      = scan_ff;
      k_in         = k_ff;
      match_in     = match_ff;
      matched_in   = matched_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      we           = 1'b0;
      wa           = scan_ff;
      wd           = first_box;
      rreq.start    = 1'b0;
      rreq.dividend = {1'b0, p_ff.x};
      rreq.divisor  = ax;
      unique case (dop_ff)
         2'd0: begin rreq.dividend = {1'b0, p_ff.x}; rreq.divisor = ax; end
         2'd1: begin rreq.dividend = vx;             rreq.divisor = ax; end
         2'd2: begin rreq.dividend = {1'b0, p_ff.y}; rreq.divisor = ay; end
         default: begin rreq.dividend = vy;          rreq.divisor = ay; end
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_data.operation;
               p_in       = '{req_data.box_x, req_data.box_y, req_data.box_z};
               s_in       = '{req_data.box_w, req_data.box_h, req_data.box_d};
               allzero_in = ({req_data.box_x, req_data.box_y, req_data.box_z,
                              req_data.box_w, req_data.box_h, req_data.box_d} == '0);
               scan_in    = '0;
               state_in   = (req_data.operation == OP_DRAIN) ? S_DRAIN : S_CHECK;
            end
         end
         S_CHECK: begin
            rsp_in = '0;
            rsp_in.full_copy   = full_ff;
            rsp_in.entry_count = 5'(cnt_ff);
            rsp_in.last        = 1'b1;
            if (bounds_bad) begin
               rsp_in.status = ST_BOUNDS;
               rsp_valid_in  = 1'b1;
               state_in      = S_WAIT;
            end else if (full_ff) begin
               rsp_in.status = ST_OK;
               rsp_valid_in  = 1'b1;
               state_in      = S_WAIT;
            end else if (!allowed) begin
               rsp_in.status = ST_DENIED;
               rsp_valid_in  = 1'b1;
               state_in      = S_WAIT;
            end else begin
               // zero size runs to the texture edge
               if (s_ff.x == '0) s_in.x = tw_ff - p_ff.x;
               if (s_ff.y == '0) s_in.y = th_ff - p_ff.y;
               if (s_ff.z == '0) s_in.z = td_ff - p_ff.z;
               status_in = ST_OK;
               dop_in    = 2'd0;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            rreq.start = 1'b1;
            state_in   = S_DIVW;
         end
         S_DIVW: begin
            if (rrsp.done) begin
               unique case (dop_ff)
                  2'd0: lo_in.x = p_ff.x - 16'(rrsp.rem);
                  2'd1: upx_in  = vx - 17'(rrsp.rem);
                  2'd2: lo_in.y = p_ff.y - 16'(rrsp.rem);
                  default: upy_in = vy - 17'(rrsp.rem);
               endcase
               dop_in   = dop_ff + 2'd1;
               state_in = (dop_ff == 2'd3) ? S_CLASS : S_DIV;
            end
         end
         S_CLASS: begin
            lo_in.z = {p_ff.z[15:2], 2'b00};
            hi_in.x = (upx_ff > {1'b0, tw_ff}) ? tw_ff : upx_ff[15:0];
            hi_in.y = (upy_ff > {1'b0, th_ff}) ? th_ff : upy_ff[15:0];
            hi_in.z = (upz > {1'b0, td_ff}) ? td_ff : upz[15:0];
            matched_in = 1'b0;
            if (lo_ff.x == '0 && lo_ff.y == '0 && p_ff.z[15:2] == '0
                && hi_in.x == tw_ff && hi_in.y == th_ff && hi_in.z == td_ff) begin
               cnt_in   = '0;
               full_in  = 1'b1;
               state_in = S_APPEND;
            end else if (pend_ff && cnt_ff != '0) begin
               scan_in  = IdxW'(cnt_ff - CntW'(1));
               state_in = S_SCAN;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_SCAN: begin
            if (ov && matched_ff) begin
               // fold the newer merged range into this one and close its slot
               we       = 1'b1;
               wd       = fold_box;
               acc_in   = fold_box;
               k_in     = match_ff;
               match_in = scan_ff;
               state_in = S_SHIFT;
            end else begin
               if (ov) begin
                  we         = 1'b1;
                  wd         = first_box;
                  acc_in     = first_box;
                  match_in   = scan_ff;
                  matched_in = 1'b1;
               end
               if (scan_ff == '0) begin
                  state_in = (ov || matched_ff) ? S_FINISH : S_APPEND;
               end else begin
                  scan_in = scan_ff - IdxW'(1);
               end
            end
         end
         S_SHIFT: begin
            if (k_next < cnt_ff) begin
               we   = 1'b1;
               wa   = k_ff;
               wd   = rd;
               k_in = k_next[IdxW-1:0];
            end else begin
               cnt_in = cnt_ff - CntW'(1);
               if (scan_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  scan_in  = scan_ff - IdxW'(1);
                  state_in = S_SCAN;
               end
            end
         end
         S_APPEND: begin
            if (cnt_ff >= CntW'(MaxRanges)) begin
               status_in = ST_FULL;
            end else begin
               we     = 1'b1;
               wa     = cnt_ff[IdxW-1:0];
               wd.s   = p_ff;
               wd.e   = '{ex_p[15:0], ey_p[15:0], ez_p[15:0]};
               cnt_in = cnt_ff + CntW'(1);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            rsp_in = '0;
            rsp_in.status        = status_ff;
            rsp_in.notify_device = (status_ff == ST_OK) && !pend_ff;
            rsp_in.full_copy     = full_ff;
            rsp_in.entry_count   = 5'(cnt_ff);
            rsp_in.last          = 1'b1;
            if (status_ff == ST_OK) pend_in = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_WAIT;
         end
         S_DRAIN: begin
            rsp_in = '0;
            rsp_in.status      = ST_OK;
            rsp_in.full_copy   = full_ff;
            rsp_in.entry_count = 5'(cnt_ff);
            if (cnt_ff == '0) begin
               rsp_in.last = 1'b1;
            end else begin
               rsp_in.entry_valid = 1'b1;
               rsp_in.out_start_x = rd.s.x;
               rsp_in.out_start_y = rd.s.y;
               rsp_in.out_start_z = rd.s.z;
               rsp_in.out_end_x   = rd.e.x;
               rsp_in.out_end_y   = rd.e.y;
               rsp_in.out_end_z   = rd.e.z;
               rsp_in.last        = (CntW'(scan_ff) == cnt_ff - CntW'(1));
            end
            rsp_valid_in = 1'b1;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (!rsp_ff.last) begin
                  scan_in  = scan_ff + IdxW'(1);
                  state_in = S_DRAIN;
               end else begin
                  if (op_ff == OP_DRAIN) begin
                     cnt_in   = '0;
                     pend_in  = 1'b0;
                     full_in  = 1'b0;
                     first_in = 1'b0;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         full_ff      <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         tw_ff        <= 16'd1;
         th_ff        <= 16'd1;
         td_ff        <= 16'd1;
         cpu_ff       <= 1'b0;
         bx_ff        <= 4'd1;
         by_ff        <= 4'd1;
         staged_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         full_ff      <= full_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_TEX_WIDTH:  tw_ff     <= csr_data;
               REG_TEX_HEIGHT: th_ff     <= csr_data;
               REG_TEX_DEPTH:  td_ff     <= csr_data;
               REG_CPU_BACKED: cpu_ff    <= csr_data[0];
               REG_ALIGN_X:    bx_ff     <= csr_data[3:0];
               REG_ALIGN_Y:    by_ff     <= csr_data[3:0];
               REG_STAGED:     staged_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
      op_ff      <= op_in;
      p_ff       <= p_in;
      s_ff       <= s_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      upx_ff     <= upx_in;
      upy_ff     <= upy_in;
      dop_ff     <= dop_in;
      allzero_ff <= allzero_in;
      scan_ff    <= scan_in;
      k_ff       <= k_in;
      match_ff   <= match_in;
      matched_ff <= matched_in;
      acc_ff     <= acc_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
      if (we) mem_ff[wa] <= wd;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;
endmodule
`default_nettype wire

// File: design/drc_rem_unit.sv
// shared bit-serial remainder unit, one quotient bit per cycle
// depends on drc_pkg
`timescale 1ns / 1ps
`default_nettype none
module drc_rem_unit
   import drc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rem_req_type req,
   output rem_rsp_type      rsp
);
   logic [16:0] dvd_ff, dvd_in;
   logic [3:0]  rem_ff, rem_in;
   logic [3:0]  div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  trial;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[16]};
      if (req.start) begin
         dvd_in  = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
         cnt_in  = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 4'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[3:0];
         end
         dvd_in = {dvd_ff[15:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;
endmodule
`default_nettype wire

// File: design/drc_checker.sv
// port-level checks for the dirty region coalescer, bound to the top level
// depends on drc_pkg and dirty_region_coalescer_core
`timescale 1ns / 1ps
`default_nettype none
module drc_checker
   import drc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire req_type     req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire rsp_type     rsp_data,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [2:0]  csr_index,
   input wire logic [15:0] csr_data
);
   // busy from request transfer until its results are out
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready for a request while a result waits");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed before transfer");

   a_entry_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_valid |->
         rsp_data.status == ST_OK && !rsp_data.notify_device
         && rsp_data.entry_count <= 5'(MaxRanges))
      else $error("drained entry with bad status or count");
endmodule

bind dirty_region_coalescer_core drc_checker u_drc_checker (.*);
`default_nettype wire

// File: dv/dirty_region_coalescer_core_test.sv
// self-checking testbench for the dirty region coalescer: directed marks and drains, then random
// traffic under three idling patterns, every result checked against an in-bench coalescing table
// depends on drc_pkg and dirty_region_coalescer_core
`timescale 1ns / 1ps
module dirty_region_coalescer_core_test;
   import drc_pkg::*;

   localparam int StallLimit = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = REG_TEX_WIDTH;
   logic [15:0] csr_data = '0;

   dirty_region_coalescer_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // texture settings as the block sees them
   int unsigned tex_dim[3];
   int unsigned cpu_backed, align_x, align_y, staged;
   // pending dirty ranges, end exclusive
   int unsigned rng_lo[MaxRanges][3];
   int unsigned rng_hi[MaxRanges][3];
   int unsigned rng_count;
   bit          dirty_pending, full_copy_pending, first_frame;

   rsp_type     expected_rsp_q[$];
   int          fails = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   logic        rsp_hold = 1'b0;
   int          quiet_cycles = 0;

   function automatic int unsigned align_dn(int unsigned v, int unsigned a);
      return v / a * a;
   endfunction

   function automatic int unsigned align_up(int unsigned v, int unsigned a);
      return (v + a - 1) / a * a;
   endfunction

   function automatic void coalesce_mark(input req_type r, output logic [1:0] st,
                                         output logic ntf);
      int unsigned p[3], s[3], lo[3], hi[3], al[3], ral[3];
      int unsigned m;
      bit blk, push, allzero, ov;
      int match;
      st = ST_OK;
      ntf = 1'b0;
      match = -1;
      p[0] = r.box_x; p[1] = r.box_y; p[2] = r.box_z;
      s[0] = r.box_w; s[1] = r.box_h; s[2] = r.box_d;
      allzero = (p[0] | p[1] | p[2] | s[0] | s[1] | s[2]) == 0;
      for (int j = 0; j < 3; j++) begin
         if (p[j] >= tex_dim[j] || p[j] + s[j] > tex_dim[j]) begin
            st = ST_BOUNDS;
            return;
         end
      end
      if (full_copy_pending) return;
      if (!cpu_backed && !(first_frame && allzero && staged)) begin
         st = ST_DENIED;
         return;
      end
      for (int j = 0; j < 3; j++) if (s[j] == 0) s[j] = tex_dim[j] - p[j];
      blk = align_x > 1 || align_y > 1;
      al[0] = blk ? (align_x != 0 ? align_x : 1) : NoBlockAlign;
      al[1] = blk ? (align_y != 0 ? align_y : 1) : NoBlockAlign;
      al[2] = NoBlockAlign;
      ral[0] = blk ? al[0] : 1;
      ral[1] = blk ? al[1] : 1;
      ral[2] = 1;
      for (int j = 0; j < 3; j++) begin
         lo[j] = align_dn(p[j], al[j]);
         hi[j] = align_up(p[j] + s[j], al[j]);
         if (hi[j] > tex_dim[j]) hi[j] = tex_dim[j];
      end
      if (hi[0] - lo[0] == tex_dim[0] && hi[1] - lo[1] == tex_dim[1] &&
          hi[2] - lo[2] == tex_dim[2]) begin
         rng_count = 0;
         full_copy_pending = 1'b1;
         push = 1'b1;
      end else if (dirty_pending) begin
         // newest first; the first hit absorbs the box, later hits fold into the older one
         for (int i = int'(rng_count) - 1; i >= 0; i--) begin
            ov = 1'b1;
            for (int j = 0; j < 3; j++)
               if (!(hi[j] >= rng_lo[i][j] && lo[j] <= rng_hi[i][j])) ov = 1'b0;
            if (!ov) continue;
            if (match < 0) begin
               for (int j = 0; j < 3; j++) begin
                  if (align_dn(p[j], ral[j]) < rng_lo[i][j])
                     rng_lo[i][j] = align_dn(p[j], ral[j]);
                  if (align_up(p[j] + s[j], ral[j]) > rng_hi[i][j])
                     rng_hi[i][j] = align_up(p[j] + s[j], ral[j]);
                  if (rng_hi[i][j] > 16'hFFFF) rng_hi[i][j] = 16'hFFFF;
               end
            end else begin
               m = match;
               for (int j = 0; j < 3; j++) begin
                  if (rng_lo[m][j] < rng_lo[i][j]) rng_lo[i][j] = rng_lo[m][j];
                  if (rng_hi[m][j] > rng_hi[i][j]) rng_hi[i][j] = rng_hi[m][j];
               end
               for (int k = m; k + 1 < rng_count; k++) begin
                  rng_lo[k] = rng_lo[k + 1];
                  rng_hi[k] = rng_hi[k + 1];
               end
               rng_count--;
            end
            match = i;
         end
         push = match < 0;
      end else begin
         push = 1'b1;
      end
      if (push) begin
         if (rng_count >= MaxRanges) begin
            st = ST_FULL;
            return;
         end
         for (int j = 0; j < 3; j++) begin
            rng_lo[rng_count][j] = p[j];
            rng_hi[rng_count][j] = p[j] + s[j];
         end
         rng_count++;
      end
      if (!dirty_pending) begin
         dirty_pending = 1'b1;
         ntf = 1'b1;
      end
   endfunction

   function automatic void queue_results(input req_type r);
      rsp_type e;
      logic [1:0] st;
      logic ntf;
      e = '0;
      if (r.operation == OP_MARK) begin
         coalesce_mark(r, st, ntf);
         e.status = st;
         e.notify_device = ntf;
         e.full_copy = full_copy_pending;
         e.entry_count = 5'(rng_count);
         e.last = 1'b1;
         expected_rsp_q.push_back(e);
      end else begin
         e.status = ST_OK;
         e.full_copy = full_copy_pending;
         e.entry_count = 5'(rng_count);
         if (rng_count == 0) begin
            e.last = 1'b1;
            expected_rsp_q.push_back(e);
         end
         for (int i = 0; i < rng_count; i++) begin
            e.entry_valid = 1'b1;
            e.out_start_x = 16'(rng_lo[i][0]);
            e.out_start_y = 16'(rng_lo[i][1]);
            e.out_start_z = 16'(rng_lo[i][2]);
            e.out_end_x = 16'(rng_hi[i][0]);
            e.out_end_y = 16'(rng_hi[i][1]);
            e.out_end_z = 16'(rng_hi[i][2]);
            e.last = i + 1 == rng_count;
            expected_rsp_q.push_back(e);
         end
         rng_count = 0;
         dirty_pending = 1'b0;
         full_copy_pending = 1'b0;
         first_frame = 1'b0;
      end
   endfunction

   function automatic void check_field(string nm, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", nm, want, got);
         fails++;
      end
   endfunction

   // receiver: random back-pressure, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected result transfer: %h", rsp_data);
            fails++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("notify_device", want.notify_device, rsp_data.notify_device);
            check_field("entry_valid", want.entry_valid, rsp_data.entry_valid);
            check_field("out_start_x", want.out_start_x, rsp_data.out_start_x);
            check_field("out_start_y", want.out_start_y, rsp_data.out_start_y);
            check_field("out_start_z", want.out_start_z, rsp_data.out_start_z);
            check_field("out_end_x", want.out_end_x, rsp_data.out_end_x);
            check_field("out_end_y", want.out_end_y, rsp_data.out_end_y);
            check_field("out_end_z", want.out_end_z, rsp_data.out_end_z);
            check_field("full_copy", want.full_copy, rsp_data.full_copy);
            check_field("entry_count", want.entry_count, rsp_data.entry_count);
            check_field("last", want.last, rsp_data.last);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // leaves valid high after the transfer so a following item can go straight out
   task automatic send_item(input req_type r);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      queue_results(r);
   endtask

   task automatic send_mark(input int unsigned x, y, z, w, h, d);
      req_type r;
      r = '{OP_MARK, x[15:0], y[15:0], z[15:0], w[15:0], h[15:0], d[15:0]};
      send_item(r);
   endtask

   task automatic send_drain();
      req_type r;
      r = '0;
      r.operation = OP_DRAIN;
      send_item(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[15:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_TEX_WIDTH:  tex_dim[0] = val & 16'hFFFF;
         REG_TEX_HEIGHT: tex_dim[1] = val & 16'hFFFF;
         REG_TEX_DEPTH:  tex_dim[2] = val & 16'hFFFF;
         REG_CPU_BACKED: cpu_backed = val & 1;
         REG_ALIGN_X:    align_x = val & 4'hF;
         REG_ALIGN_Y:    align_y = val & 4'hF;
         REG_STAGED:     staged = val & 1;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_texture(input int unsigned w, h, d, cpu, ax, ay, stg);
      wait_idle();
      write_reg(REG_TEX_WIDTH, w);
      write_reg(REG_TEX_HEIGHT, h);
      write_reg(REG_TEX_DEPTH, d);
      write_reg(REG_CPU_BACKED, cpu);
      write_reg(REG_ALIGN_X, ax);
      write_reg(REG_ALIGN_Y, ay);
      write_reg(REG_STAGED, stg);
   endtask

   // first-frame exception on the reset settings, then denial once the frame has ended
   task automatic test_first_frame();
      send_mark(0, 0, 0, 0, 0, 0);
      send_mark(0, 0, 0, 1, 1, 1);
      send_drain();
      send_mark(0, 0, 0, 0, 0, 0);
      send_drain();
   endtask

   task automatic test_bounds_and_fill();
      set_texture(256, 16, 8, 1, 1, 1, 0);
      send_mark(256, 0, 0, 1, 1, 1);
      send_mark(250, 0, 0, 7, 1, 1);
      send_mark(0, 16, 0, 1, 1, 1);
      send_mark(0, 0, 7, 1, 1, 2);
      // seventeen separated boxes, the last refused
      for (int i = 0; i < 17; i++) send_mark(i * 8, 2, 1, 1, 1, 1);
      send_drain();
      send_drain();
   endtask

   task automatic test_merge_fold();
      set_texture(64, 64, 4, 1, 1, 1, 1);
      send_mark(0, 0, 0, 1, 1, 1);
      send_mark(16, 0, 0, 1, 1, 1);
      send_mark(40, 40, 2, 3, 3, 1);
      send_mark(1, 0, 0, 18, 2, 1);
      send_mark(3, 5, 0, 0, 0, 0);
      send_drain();
      // full-range box replaces the table; later marks change nothing
      send_mark(5, 5, 0, 2, 2, 1);
      send_mark(0, 0, 0, 0, 0, 0);
      send_mark(9, 9, 1, 1, 1, 1);
      send_drain();
   endtask

   task automatic test_align_extremes();
      set_texture(65535, 65535, 65535, 1, 12, 0, 1);
      send_mark(65520, 100, 3, 6, 1, 1);
      send_mark(65530, 101, 3, 5, 1, 1);
      send_mark(65535, 0, 0, 1, 1, 1);
      send_drain();
      set_texture(1, 1, 1, 0, 15, 15, 0);
      send_mark(0, 0, 0, 0, 0, 0);
      send_drain();
   endtask

   function automatic int unsigned pick_pos(int unsigned lim);
      if ($urandom_range(0, 1)) return $urandom_range(0, lim - 1);
      return $urandom_range(0, (lim > 64 ? 64 : lim) - 1);
   endfunction

   function automatic int unsigned pick_size(int unsigned room);
      int unsigned cap;
      cap = room > 9 ? 9 : room;
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(1, room);
         default: return $urandom_range(1, cap);
      endcase
   endfunction

   task automatic random_traffic(input int n);
      req_type r;
      int unsigned sel;
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(0, 99);
         r = '0;
         if (sel < 10) begin
            r.operation = OP_DRAIN;
            if ($urandom_range(0, 1)) r[95:0] = {$urandom, $urandom, $urandom};
         end else if (sel < 20) begin
            r = {1'b0, $urandom, $urandom, $urandom};
         end else begin
            r.operation = OP_MARK;
            r.box_x = 16'(pick_pos(tex_dim[0]));
            r.box_y = 16'(pick_pos(tex_dim[1]));
            r.box_z = 16'(pick_pos(tex_dim[2]));
            r.box_w = 16'(pick_size(tex_dim[0] - r.box_x));
            r.box_h = 16'(pick_size(tex_dim[1] - r.box_y));
            r.box_d = 16'(pick_size(tex_dim[2] - r.box_z));
         end
         send_item(r);
      end
   endtask

   task automatic test_random();
      req_idle_pct = 22;
      rsp_idle_pct = 55;
      set_texture(64, 32, 8, 1, 1, 1, 1);
      random_traffic(115);
      req_idle_pct = 55;
      rsp_idle_pct = 22;
      set_texture(65535, 65535, 65535, 1, 12, 3, 0);
      random_traffic(115);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_texture(40, 24, 5, 1, 0, 7, 1);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (600) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      random_traffic(115);
   endtask

   initial begin
      tex_dim = '{1, 1, 1};
      cpu_backed = 0;
      align_x = 1;
      align_y = 1;
      staged = 1;
      rng_count = 0;
      dirty_pending = 1'b0;
      full_copy_pending = 1'b0;
      first_frame = 1'b1;
      req_idle_pct = 22;
      rsp_idle_pct = 55;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_frame();
      test_bounds_and_fill();
      test_merge_fold();
      test_align_extremes();
      test_random();
      wait_idle();
      if (fails == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/drc_pkg.sv
design/drc_rem_unit.sv
design/dirty_region_coalescer_core.sv
design/drc_checker.sv
dv/dirty_region_coalescer_core_test.sv
